// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define HHF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define HHF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== src/hhf_pkg.sv =====
package hhf_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int PAT_LEN_W         = 6;
  localparam int POS_W             = 16;
  localparam int IHL_W             = 6;
  localparam int PS_W              = 7;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int PAT_BITS          = MAX_PATTERN_BYTES * 8;

  // first position that is no longer examined; saturate there
  localparam logic [POS_W-1:0] POS_LIMIT = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 3'd4;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hhf_word_t;

  typedef struct packed {
    logic [PAT_BITS-1:0]  pattern;
    logic [PAT_LEN_W-1:0] used_len;
  } hhf_cfg_t;

  typedef struct packed {
    logic drop;
    logic req;
  } hhf_verdict_t;

  function automatic logic [7:0] get_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h47;  // G
      2'd1:    c = 8'h45;  // E
      2'd2:    c = 8'h54;  // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h50;  // P
      2'd1:    c = 8'h4F;  // O
      2'd2:    c = 8'h53;  // S
      default: c = 8'h54;  // T
    endcase
    return c;
  endfunction

  function automatic logic [7:0] host_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = 8'h48;  // H
      2'd1:    c = 8'h6F;  // o
      2'd2:    c = 8'h73;  // s
      default: c = 8'h74;  // t
    endcase
    return c;
  endfunction

endpackage

// ===== src/hhf_cfg_regs.sv =====
module hhf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [hhf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hhf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hhf_pkg::hhf_cfg_t                cfg
);
  import hhf_pkg::*;

  logic [3:0][CFG_DATA_W-1:0] pattern_r;
  logic [PAT_LEN_W-1:0]       pat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      pat_len_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        CFG_PAT_0_7, CFG_PAT_8_15, CFG_PAT_16_23, CFG_PAT_24_31: begin
          pattern_r[cfg_index[1:0]] <= cfg_data;
        end
        CFG_PAT_LEN: begin
          pat_len_r <= cfg_data[PAT_LEN_W-1:0];
        end
        default: begin
          // unknown index: ignore
        end
      endcase
    end
  end

  // clamp length to the pattern storage
  assign cfg.pattern  = pattern_r;
  assign cfg.used_len = (pat_len_r > PAT_LEN_W'(MAX_PATTERN_BYTES))
                        ? PAT_LEN_W'(MAX_PATTERN_BYTES) : pat_len_r;

endmodule

// ===== src/hhf_in_reg.sv =====
module hhf_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_packet_byte,
  input  logic               in_end_of_packet,
  output logic               s1_valid,
  output hhf_pkg::hhf_word_t s1_word,
  input  logic               s1_take
);
  import hhf_pkg::*;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  hhf_word_t s1_word_r;
  logic      load;

  // free when empty or when the held word moves on this cycle
  assign in_ready = !s1_valid_r || s1_take;
  assign load     = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_word_r.data <= in_packet_byte;
      s1_word_r.last <= in_end_of_packet;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;

endmodule

// ===== src/hhf_parser.sv =====
module hhf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hhf_pkg::hhf_cfg_t     cfg,
  input  logic                  s1_valid,
  input  hhf_pkg::hhf_word_t    s1_word,
  output logic                  s1_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hhf_pkg::hhf_verdict_t verdict
);
  import hhf_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IHL_W-1:0] ihl_r, ihl_nxt;
  logic [PS_W-1:0]  ps_r, ps_nxt;
  logic             onz_r, onz_nxt;
  logic             get_r, get_nxt;
  logic             post_r, post_nxt;
  logic             host_r, host_nxt;
  logic             pat_r, pat_nxt;

  logic             out_valid_r, out_valid_nxt;
  hhf_verdict_t     verdict_r, verdict_nxt;

  logic [7:0]       b;
  logic [IHL_W-1:0] ihl_cur;
  logic [IHL_W-1:0] off;
  logic [POS_W-1:0] rel;
  logic [4:0]       pat_idx;
  logic [7:0]       pat_byte;
  logic             hit_off;
  logic             in_payload;
  logic [POS_W:0]   n_ext;
  logic [POS_W:0]   ps_ext;
  logic             req;
  logic             host_ok;
  logic             drop;

  // a last word needs the result register free
  assign s1_take = s1_valid && (!s1_word.last || !out_valid_r || out_ready);

  assign pat_idx  = rel[4:0] - 5'd22;
  assign pat_byte = cfg.pattern[{pat_idx, 3'b000} +: 8];

  always_comb begin
    b        = s1_word.data;
    pos_nxt  = pos_r;
    ihl_nxt  = ihl_r;
    ps_nxt   = ps_r;
    onz_nxt  = onz_r;
    get_nxt  = get_r;
    post_nxt = post_r;
    host_nxt = host_r;
    pat_nxt  = pat_r;

    ihl_cur    = (pos_r == '0) ? {b[3:0], 2'b00} : ihl_r;
    off        = {b[7:4], 2'b00};
    rel        = pos_r - POS_W'(ps_r);
    hit_off    = !onz_r && ({1'b0, pos_r} == (17'(ihl_cur) + 17'd12));
    in_payload = onz_r && (pos_r >= POS_W'(ps_r));

    if (pos_r != POS_LIMIT) begin
      ihl_nxt = ihl_cur;
      if (hit_off) begin
        ps_nxt  = PS_W'(7'(ihl_cur) + 7'(off));
        onz_nxt = (off != '0);
        if (off <= 6'd12) begin
          get_nxt  = 1'b0;
          post_nxt = 1'b0;
        end
      end else if (in_payload) begin
        if (rel < 16'd3 && b != get_char(rel[1:0])) begin
          get_nxt = 1'b0;
        end
        if (rel < 16'd4 && b != post_char(rel[1:0])) begin
          post_nxt = 1'b0;
        end
        if (rel >= 16'd16 && rel < 16'd20 && b != host_char(rel[1:0])) begin
          host_nxt = 1'b0;
        end
        if (rel >= 16'd22 && {1'b0, rel} < (17'd22 + 17'(cfg.used_len))) begin
          if (b == CHAR_CR || b != pat_byte) begin
            pat_nxt = 1'b0;
          end
        end
      end
      pos_nxt = pos_r + 1'b1;
    end

    // verdict from the updated state
    n_ext   = {1'b0, pos_nxt};
    ps_ext  = 17'(ps_nxt);
    req     = onz_nxt && ((get_nxt && n_ext >= ps_ext + 17'd3) ||
                          (post_nxt && n_ext >= ps_ext + 17'd4));
    host_ok = req && host_nxt && n_ext >= ps_ext + 17'd20;
    drop    = host_ok && pat_nxt &&
              n_ext >= ps_ext + 17'd22 + 17'(cfg.used_len);

    // clear packet state after the last word
    if (s1_word.last) begin
      pos_nxt  = '0;
      ihl_nxt  = '0;
      ps_nxt   = '0;
      onz_nxt  = 1'b0;
      get_nxt  = 1'b1;
      post_nxt = 1'b1;
      host_nxt = 1'b1;
      pat_nxt  = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    verdict_nxt   = verdict_r;
    if (s1_take && s1_word.last) begin
      out_valid_nxt    = 1'b1;
      verdict_nxt.drop = drop;
      verdict_nxt.req  = req;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ihl_r       <= '0;
      ps_r        <= '0;
      onz_r       <= 1'b0;
      get_r       <= 1'b1;
      post_r      <= 1'b1;
      host_r      <= 1'b1;
      pat_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        pos_r  <= pos_nxt;
        ihl_r  <= ihl_nxt;
        ps_r   <= ps_nxt;
        onz_r  <= onz_nxt;
        get_r  <= get_nxt;
        post_r <= post_nxt;
        host_r <= host_nxt;
        pat_r  <= pat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  assign out_valid = out_valid_r;
  assign verdict   = verdict_r;

endmodule

// ===== src/http_host_packet_filter_top.sv =====
// HTTP Host filter. Feed an IPv4 packet one byte per word, starting at the
// IP header, with in_end_of_packet set on the final byte. The block locates
// the TCP payload from the IP header length and the TCP data offset, checks
// for a GET or POST request, checks for "Host" at payload offset 16, and
// compares the host bytes from payload offset 22 against the configured
// pattern. Exactly one verdict word comes out per packet, on the last byte:
// out_drop_packet is 1 when every pattern byte matched before any CR (an
// empty pattern matches any host), and out_http_request_seen tells whether
// the payload began with GET or POST. A packet that ends before a needed
// byte counts as no match; bytes past position 65534 are not examined.
// Rate: one byte per clock, sustained. Each byte is held in an input
// register, then compare and counter logic updates the packet state and
// loads the verdict register, so the verdict shows in the cycle after the
// last byte is taken. The input stalls only when a last byte meets a
// verdict that is still waiting on out_ready. Configuration writes
// (indexes 0 to 3 pattern bytes, 4 pattern length) are always accepted,
// and belong in idle time between packets.
`include "assert_macros.svh"

module http_host_packet_filter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_packet_byte,
  input  logic                                in_end_of_packet,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_drop_packet,
  output logic                                out_http_request_seen,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hhf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hhf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hhf_pkg::*;

  hhf_cfg_t     cfg;
  logic         s1_valid;
  hhf_word_t    s1_word;
  logic         s1_take;
  hhf_verdict_t verdict;

  // register file never stalls
  assign cfg_ready = 1'b1;

  hhf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // hold the incoming byte in an input register
  hhf_in_reg u_in_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_packet_byte   (in_packet_byte),
    .in_end_of_packet (in_end_of_packet),
    .s1_valid         (s1_valid),
    .s1_word          (s1_word),
    .s1_take          (s1_take)
  );

  // advance the packet state and load the verdict on the last byte
  hhf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
  );

  assign out_drop_packet       = verdict.drop;
  assign out_http_request_seen = verdict.req;

  // a drop is only possible for a recognized request
  `HHF_ASSERT_IMP(a_drop_needs_req, out_valid && out_drop_packet, out_http_request_seen)
  // input stalls only behind a waiting verdict and a held last byte
  `HHF_ASSERT_IMP(a_stall_cause, !in_ready, s1_valid && s1_word.last && out_valid && !out_ready)
  // a taken last byte always yields a verdict next cycle
  `HHF_ASSERT_NXT(a_last_gives_verdict, s1_take && s1_word.last, out_valid)

endmodule
